// ===== sv/multi_organization_cache_hit_counter_assert.svh =====
// Assertion macros for the cache hit counter.
`ifndef MULTI_ORGANIZATION_CACHE_HIT_COUNTER_ASSERT_SVH
`define MULTI_ORGANIZATION_CACHE_HIT_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define MOC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MOC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/mochc_pkg.sv =====
// ----------------------------------------------------------------------------
// mochc_pkg
// Shared constants and types for the multi-organization cache hit counter.
// ----------------------------------------------------------------------------
package mochc_pkg;
    localparam int LineCount   = 32;
    localparam int BlockBytes  = 4;
    localparam int AddrBits    = 32;
    localparam int OffBits     = $clog2(BlockBytes);
    localparam int BlkBits     = AddrBits - OffBits;
    localparam int NumOrg      = 4;
    localparam int RankBits    = $clog2(LineCount);
    localparam int IdxBits     = $clog2(LineCount);
    localparam int CntBits     = 32;

    // Per-cell control broadcast for one organization
    typedef struct packed {
        logic               act;      // update this cycle
        logic [IdxBits-1:0] set_id;   // set being accessed
        logic [BlkBits-1:0] tag;      // block tag (aligned, full width)
        logic               hit;      // some way of the set hit
        logic [RankBits-1:0] hit_rank;
        logic               have_free;
        logic [IdxBits-1:0] pick_way;
    } t_upd;

    typedef struct packed {
        logic               in_set;
        logic               valid;
        logic               match;
        logic [RankBits-1:0] rank;
    } t_cell_stat;
endpackage

// ===== sv/mochc_cell.sv =====
// ----------------------------------------------------------------------------
// mochc_cell
// One cache line: tag, valid bit and age rank, with match and LRU update.
// ----------------------------------------------------------------------------
module mochc_cell
    import mochc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IdxBits-1:0] i_my_set,
    input  logic [IdxBits-1:0] i_my_way,
    input  logic [BlkBits-1:0] i_look_tag,
    input  logic [IdxBits-1:0] i_look_set,
    input  t_upd               i_upd,
    output t_cell_stat         o_stat
);
    logic [BlkBits-1:0]  r_tag;
    logic                r_valid;
    logic [RankBits-1:0] r_rank;
    logic                w_mine;
    logic                w_pick;

    // Lookup status
    assign o_stat.in_set = (i_look_set == i_my_set);
    assign o_stat.valid  = r_valid;
    assign o_stat.match  = r_valid && (r_tag == i_look_tag);
    assign o_stat.rank   = r_rank;

    assign w_mine = i_upd.act && (i_upd.set_id == i_my_set);
    assign w_pick = w_mine && (i_upd.pick_way == i_my_way);

    // Update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
            r_tag   <= '0;
        end else if (w_pick) begin
            r_valid <= 1'b1;
            r_rank  <= '0;
            r_tag   <= i_upd.tag;
        end else if (w_mine && r_valid) begin
            if (!i_upd.hit && i_upd.have_free)
                r_rank <= r_rank + 1'b1;
            else if (r_rank < i_upd.hit_rank)
                r_rank <= r_rank + 1'b1;
        end
    end
endmodule

// ===== sv/mochc_org.sv =====
// ----------------------------------------------------------------------------
// mochc_org
// The four organizations: each a row of line cells plus set-level way selection.
// ----------------------------------------------------------------------------
module mochc_org
    import mochc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_act,
    input  logic [BlkBits-1:0] i_block,
    output logic [NumOrg-1:0]  o_hit
);
    // Slots 0..2 hold 1, 2 and 4 ways; the last slot is fully associative
    for (genvar o = 0; o < NumOrg; o++) begin : g_org
        localparam int Ways    = (o == NumOrg - 1) ? LineCount : (1 << o);
        localparam int Sets    = LineCount / Ways;
        localparam int SetBits = (Sets > 1) ? $clog2(Sets) : 1;

        t_cell_stat          w_stat [LineCount];
        t_upd                w_upd;
        logic [IdxBits-1:0]  w_set;
        logic [BlkBits-1:0]  w_tag;
        logic                w_hit;
        logic                w_free;
        logic [IdxBits-1:0]  w_hway;
        logic [IdxBits-1:0]  w_fway;
        logic [IdxBits-1:0]  w_lway;
        logic [RankBits-1:0] w_hrank;
        logic [RankBits-1:0] w_lrank;

        // Address split
        always_comb begin
            w_set = '0;
            if (Sets > 1) w_set = IdxBits'(i_block[SetBits-1:0]);
            w_tag = (Sets > 1) ? (i_block >> SetBits) : i_block;
        end

        // Row of cells
        for (genvar g = 0; g < LineCount; g++) begin : g_cell
            mochc_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_my_set   (IdxBits'(g / Ways)),
                .i_my_way   (IdxBits'(g % Ways)),
                .i_look_tag (w_tag),
                .i_look_set (w_set),
                .i_upd      (w_upd),
                .o_stat     (w_stat[g])
            );
        end

        // Way selection across the set; with every way valid the ranks are
        // 0..Ways-1, so the LRU way is the one holding rank Ways-1
        always_comb begin
            w_hit = 1'b0; w_free = 1'b0;
            w_hway = '0; w_fway = '0; w_lway = '0;
            w_hrank = '0;
            w_lrank = RankBits'(Ways - 1);
            for (int i = LineCount - 1; i >= 0; i--) begin
                if (w_stat[i].in_set) begin
                    if (w_stat[i].match) begin
                        w_hit = 1'b1;
                        w_hway = IdxBits'(i % Ways);
                        w_hrank = w_stat[i].rank;
                    end
                    if (!w_stat[i].valid) begin
                        w_free = 1'b1;
                        w_fway = IdxBits'(i % Ways);
                    end
                    if (w_stat[i].rank == RankBits'(Ways - 1))
                        w_lway = IdxBits'(i % Ways);
                end
            end
            w_upd.act       = i_act;
            w_upd.set_id    = w_set;
            w_upd.tag       = w_tag;
            w_upd.hit       = w_hit;
            w_upd.have_free = w_free;
            w_upd.hit_rank  = w_hit ? w_hrank : w_lrank;
            w_upd.pick_way  = w_hit ? w_hway : (w_free ? w_fway : w_lway);
        end

        assign o_hit[o] = w_hit;
    end
endmodule

// ===== sv/multi_organization_cache_hit_counter.sv =====
// Result strobe is registered and rises in the cycle after start is accepted.
// Throughput: one address per cycle; busy stays low.
// All four organizations compare in parallel across their line cells.
// Synchronous active-low reset clears valid bits, ranks and all totals.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
// multi_organization_cache_hit_counter
// Tracks hits of four cache organizations on one address stream.
// ----------------------------------------------------------------------------
`include "multi_organization_cache_hit_counter_assert.svh"
module multi_organization_cache_hit_counter
    import mochc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_byte_address,
    output logic               o_strobe,
    output logic               o_direct_hit,
    output logic               o_two_way_hit,
    output logic               o_four_way_hit,
    output logic               o_full_hit,
    output logic [31:0]        o_direct_hit_total,
    output logic [31:0]        o_two_way_hit_total,
    output logic [31:0]        o_four_way_hit_total,
    output logic [31:0]        o_full_hit_total,
    output logic [31:0]        o_access_total
);
    logic               w_acc;
    logic [BlkBits-1:0] w_blk;
    logic [NumOrg-1:0]  w_hit;
    logic               r_strobe;
    logic [NumOrg-1:0]  r_hit;
    logic [CntBits-1:0] r_cnt [NumOrg];
    logic [CntBits-1:0] r_acc;

    assign busy  = 1'b0;
    assign w_acc = start && !busy;
    assign w_blk = i_byte_address[AddrBits-1:OffBits];

    // Four organizations
    mochc_org u_org (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_act   (w_acc),
        .i_block (w_blk),
        .o_hit   (w_hit)
    );

    // Totals and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_hit    <= '0;
            r_acc    <= '0;
            for (int i = 0; i < NumOrg; i++) r_cnt[i] <= '0;
        end else begin
            r_strobe <= w_acc;
            if (w_acc) begin
                r_hit <= w_hit;
                r_acc <= r_acc + 1'b1;
                for (int i = 0; i < NumOrg; i++)
                    if (w_hit[i]) r_cnt[i] <= r_cnt[i] + 1'b1;
            end
        end
    end

    assign o_strobe             = r_strobe;
    assign o_direct_hit         = r_hit[0];
    assign o_two_way_hit        = r_hit[1];
    assign o_four_way_hit       = r_hit[2];
    assign o_full_hit           = r_hit[3];
    assign o_direct_hit_total   = r_cnt[0];
    assign o_two_way_hit_total  = r_cnt[1];
    assign o_four_way_hit_total = r_cnt[2];
    assign o_full_hit_total     = r_cnt[3];
    assign o_access_total       = r_acc;

    // Access total and strobe follow accepted transactions only
    `MOC_ASSERT_NEXT(a_acc_inc, i_clk, i_rst_n, w_acc, r_acc == $past(r_acc) + 1'b1)
    `MOC_ASSERT_NEXT(a_strobe, i_clk, i_rst_n, w_acc, o_strobe)
    `MOC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !w_acc, $stable(r_acc) && !o_strobe)
endmodule
